// ===== sv/rxdf_pkg.sv =====
// ----------------------------------------------------------------------------
// rxdf_pkg
// shared types, codes and sizes of the receive duplicate filter
// ----------------------------------------------------------------------------
`default_nettype none

package rxdf_pkg;

   localparam int SEQ_ENTRIES = 20;
   localparam int QUEUE_DEPTH = 10;

   localparam int SEQ_IDX_W = $clog2(SEQ_ENTRIES);
   localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W    = 8;
   localparam int PROTO_W   = 3;
   localparam int TICK_W    = 32;
   localparam int KIND_W    = 2;
   localparam int VERDICT_W = 3;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 4;
   localparam int SEQ_W     = 16;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [ADDR_W-1:0]  DEFAULT_OWN_ADDRESS  = 8'h01;
   localparam logic [TICK_W-1:0]  DEFAULT_WINDOW       = 32'd16000;
   localparam logic [PROTO_W-1:0] DEFAULT_ACK_PROTOCOL = 3'd1;

   // register indexes
   localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
   localparam logic [1:0] REG_DUP_WINDOW  = 2'd1;
   localparam logic [1:0] REG_ACK_PROTO   = 2'd2;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_PACKET    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREED     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BURST_END = 2'd2;

   // verdicts
   localparam logic [VERDICT_W-1:0] VERDICT_ACK_OURS  = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACK_OTHER = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_DROP_TX   = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_Q_FULL    = 3'd5;
   localparam logic [VERDICT_W-1:0] VERDICT_CRC_FAIL  = 3'd6;
   localparam logic [VERDICT_W-1:0] VERDICT_HOUSE     = 3'd7;

   typedef struct packed {
      logic [ADDR_W-1:0]  own_address;
      logic [TICK_W-1:0]  dup_window;
      logic [PROTO_W-1:0] ack_protocol_id;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source;
      logic              ident;
      logic [TICK_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] source;
      logic              ident;
      logic [TICK_W-1:0] now;
   } tbl_req_type;

   typedef struct packed {
      logic done;
      logic dup;
   } tbl_rsp_type;

endpackage

`default_nettype wire

// ===== sv/rxdf_ram.sv =====
// ----------------------------------------------------------------------------
// rxdf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rxdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rxdf_csr.sv =====
// ----------------------------------------------------------------------------
// rxdf_csr
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module rxdf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rxdf_pkg::CSR_AW-1:0] paddr,
   input  logic [rxdf_pkg::CSR_DW-1:0] pwdata,
   output logic [rxdf_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output rxdf_pkg::cfg_type           cfg
);

   import rxdf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_stb;

   assign reg_idx = paddr[3:2];
   assign wr_stb  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_OWN_ADDRESS: cfg_in.own_address     = pwdata[ADDR_W-1:0];
            REG_DUP_WINDOW:  cfg_in.dup_window      = pwdata[TICK_W-1:0];
            REG_ACK_PROTO:   cfg_in.ack_protocol_id = pwdata[PROTO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OWN_ADDRESS: prdata = CSR_DW'(cfg_ff.own_address);
         REG_DUP_WINDOW:  prdata = CSR_DW'(cfg_ff.dup_window);
         REG_ACK_PROTO:   prdata = CSR_DW'(cfg_ff.ack_protocol_id);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address     <= DEFAULT_OWN_ADDRESS;
         cfg_ff.dup_window      <= DEFAULT_WINDOW;
         cfg_ff.ack_protocol_id <= DEFAULT_ACK_PROTOCOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/rxdf_seq_table.sv =====
// ----------------------------------------------------------------------------
// rxdf_seq_table
// timestamped sequence table: lookup walk, source purge and insert
// ----------------------------------------------------------------------------
`default_nettype none

module rxdf_seq_table (
   input  logic                        clock,
   input  logic                        reset,
   input  rxdf_pkg::tbl_req_type       tbl_req,
   input  logic [rxdf_pkg::TICK_W-1:0] dup_window,
   output rxdf_pkg::tbl_rsp_type       tbl_rsp
);

   import rxdf_pkg::*;

   localparam logic [1:0] TB_IDLE  = 2'd0;
   localparam logic [1:0] TB_WALK  = 2'd1;
   localparam logic [1:0] TB_PURGE = 2'd2;
   localparam logic [1:0] TB_WRITE = 2'd3;

   logic [1:0]             phase_ff, phase_in;
   logic [SEQ_IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [SEQ_IDX_W-1:0]   ins_pos_ff, ins_pos_in;
   logic [SEQ_ENTRIES-1:0] valid_ff, valid_in;
   logic                   rd_vld_ff, rd_vld_in;

   logic                 rd_en, wr_en;
   logic [SEQ_IDX_W-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0]   rd_raw;
   entry_type            entry, wr_data;
   logic                 last_idx, src_match, key_match, young;
   logic [TICK_W-1:0]    age;

   // entries never written read as zero
   assign entry     = rd_vld_ff ? entry_type'(rd_raw) : '0;
   assign src_match = entry.source == tbl_req.source;
   assign key_match = src_match && (entry.ident == tbl_req.ident);
   assign age       = tbl_req.now - entry.stamp;
   assign young     = age < dup_window;
   assign last_idx  = pend_idx_ff == SEQ_IDX_W'(SEQ_ENTRIES - 1);

   always_comb begin
      phase_in       = phase_ff;
      pend_idx_in    = pend_idx_ff;
      ins_pos_in     = ins_pos_ff;
      rd_en          = 1'b0;
      rd_addr        = pend_idx_ff + SEQ_IDX_W'(1);
      wr_en          = 1'b0;
      wr_addr        = pend_idx_ff;
      wr_data.source = '0;
      wr_data.ident  = entry.ident;
      wr_data.stamp  = entry.stamp;
      tbl_rsp        = '0;
      case (phase_ff)
         TB_IDLE: begin
            if (tbl_req.start) begin
               rd_en       = 1'b1;
               rd_addr     = '0;
               pend_idx_in = '0;
               phase_in    = TB_WALK;
            end
         end
         TB_WALK: begin
            if (key_match && young) begin
               tbl_rsp.done = 1'b1;
               tbl_rsp.dup  = 1'b1;
               phase_in     = TB_IDLE;
            end else begin
               // expired match loses its source
               wr_en = key_match;
               rd_en = 1'b1;
               if (last_idx) begin
                  rd_addr     = '0;
                  pend_idx_in = '0;
                  phase_in    = TB_PURGE;
               end else begin
                  pend_idx_in = pend_idx_ff + SEQ_IDX_W'(1);
               end
            end
         end
         TB_PURGE: begin
            wr_en = src_match;
            if (last_idx) begin
               phase_in = TB_WRITE;
            end else begin
               rd_en       = 1'b1;
               pend_idx_in = pend_idx_ff + SEQ_IDX_W'(1);
            end
         end
         TB_WRITE: begin
            wr_en          = 1'b1;
            wr_addr        = ins_pos_ff;
            wr_data.source = tbl_req.source;
            wr_data.ident  = tbl_req.ident;
            wr_data.stamp  = tbl_req.now;
            ins_pos_in     = (ins_pos_ff == SEQ_IDX_W'(SEQ_ENTRIES - 1)) ?
                             '0 : ins_pos_ff + SEQ_IDX_W'(1);
            tbl_rsp.done   = 1'b1;
            phase_in       = TB_IDLE;
         end
         default: phase_in = TB_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_vld_in = rd_en ? valid_ff[rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= TB_IDLE;
         pend_idx_ff <= '0;
         ins_pos_ff  <= '0;
         valid_ff    <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pend_idx_ff <= pend_idx_in;
         ins_pos_ff  <= ins_pos_in;
         valid_ff    <= valid_in;
         rd_vld_ff   <= rd_vld_in;
      end
   end

   rxdf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SEQ_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_data)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

endmodule

`default_nettype wire

// ===== sv/radio_rx_duplicate_filter_top.sv =====
// ----------------------------------------------------------------------------
// radio_rx_duplicate_filter_top
// classifies received packet headers, filters duplicates, keeps rx queue count
// ----------------------------------------------------------------------------
// words that skip the table get rsp_strobe from the registered commit after the eval state
// a table lookup walks, then purges the sequence ram one entry per cycle, then inserts;
// a duplicate ends the walk early
// one word at a time: busy is high from acceptance until the result strobe
// reset restores register defaults, empties the queue and marks all table entries zero
`default_nettype none

module radio_rx_duplicate_filter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rxdf_pkg::KIND_W-1:0]    req_kind,
   input  logic                           req_crc_ok,
   input  logic [rxdf_pkg::ADDR_W-1:0]    req_dest_address,
   input  logic [rxdf_pkg::ADDR_W-1:0]    req_source_address,
   input  logic [rxdf_pkg::PROTO_W-1:0]   req_protocol_number,
   input  logic                           req_ident_bit,
   input  logic                           req_transmitting,
   input  logic [rxdf_pkg::TICK_W-1:0]    req_now_ticks,
   output logic                           rsp_strobe,
   output logic [rxdf_pkg::VERDICT_W-1:0] rsp_verdict,
   output logic                           rsp_ack_needed,
   output logic [rxdf_pkg::ADDR_W-1:0]    rsp_ack_destination,
   output logic [rxdf_pkg::SLOT_W-1:0]    rsp_queue_slot,
   output logic [rxdf_pkg::COUNT_W-1:0]   rsp_queue_count,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rxdf_pkg::CSR_AW-1:0]    paddr,
   input  logic [rxdf_pkg::CSR_DW-1:0]    pwdata,
   output logic [rxdf_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);

   import rxdf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [KIND_W-1:0]  kind_ff;
   logic               crc_ok_ff;
   logic [ADDR_W-1:0]  dest_ff;
   logic [ADDR_W-1:0]  src_ff;
   logic [PROTO_W-1:0] proto_ff;
   logic               ident_ff;
   logic               tx_ff;
   logic [TICK_W-1:0]  now_ff;

   logic [SEQ_W-1:0]  last_seq_ff, last_seq_in;
   logic [QIDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic                 strobe_ff;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   logic                 ack_ff, ack_in;
   logic [ADDR_W-1:0]    ack_dest_ff;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [COUNT_W-1:0]   count_ff;

   cfg_type     cfg;
   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;

   logic             accept, need_table, commit;
   logic [SEQ_W-1:0] seq_key;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = state_ff != ST_IDLE;
   assign seq_key = {src_ff, 7'd0, ident_ff};

   always_comb begin
      verdict_in  = VERDICT_HOUSE;
      ack_in      = 1'b0;
      slot_in     = '0;
      need_table  = 1'b0;
      last_seq_in = last_seq_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      case (kind_ff)
         KIND_FREED: begin
            if (fill_ff != '0) begin
               slot_in = SLOT_W'(head_ff);
               fill_in = fill_ff - FILL_W'(1);
               head_in = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ?
                         '0 : head_ff + QIDX_W'(1);
            end
         end
         KIND_BURST_END: last_seq_in = '0;
         KIND_PACKET: begin
            if (!crc_ok_ff) begin
               verdict_in  = VERDICT_CRC_FAIL;
               last_seq_in = '0;
            end else if ((proto_ff == cfg.ack_protocol_id) && tx_ff) begin
               verdict_in = (dest_ff == cfg.own_address) ?
                            VERDICT_ACK_OURS : VERDICT_ACK_OTHER;
            end else if (tx_ff) begin
               verdict_in = VERDICT_DROP_TX;
            end else begin
               if (fill_ff >= FILL_W'(QUEUE_DEPTH - 1)) begin
                  verdict_in = VERDICT_Q_FULL;
               end else begin
                  verdict_in = VERDICT_DUPLICATE;
                  if (last_seq_ff != seq_key) begin
                     need_table = 1'b1;
                     if (!tbl_rsp.dup) begin
                        verdict_in  = VERDICT_ACCEPTED;
                        last_seq_in = seq_key;
                        slot_in     = SLOT_W'(tail_ff);
                        fill_in     = fill_ff + FILL_W'(1);
                        tail_in     = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : tail_ff + QIDX_W'(1);
                     end
                  end
               end
               if ((dest_ff == cfg.own_address) && (proto_ff != cfg.ack_protocol_id)) begin
                  ack_in      = 1'b1;
                  last_seq_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign commit = ((state_ff == ST_EVAL) && !need_table) ||
                   ((state_ff == ST_WAIT) && tbl_rsp.done);

   assign tbl_req.start  = (state_ff == ST_EVAL) && need_table;
   assign tbl_req.source = src_ff;
   assign tbl_req.ident  = ident_ff;
   assign tbl_req.now    = now_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_EVAL;
         ST_EVAL: state_in = need_table ? ST_WAIT : ST_IDLE;
         ST_WAIT: if (tbl_rsp.done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         crc_ok_ff <= req_crc_ok;
         dest_ff   <= req_dest_address;
         src_ff    <= req_source_address;
         proto_ff  <= req_protocol_number;
         ident_ff  <= req_ident_bit;
         tx_ff     <= req_transmitting;
         now_ff    <= req_now_ticks;
      end
      if (commit) begin
         verdict_ff  <= verdict_in;
         ack_ff      <= ack_in;
         ack_dest_ff <= ack_in ? src_ff : '0;
         slot_ff     <= slot_in;
         count_ff    <= COUNT_W'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         strobe_ff   <= 1'b0;
         last_seq_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= commit;
         if (commit) begin
            last_seq_ff <= last_seq_in;
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            fill_ff     <= fill_in;
         end
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_ack_needed      = ack_ff;
   assign rsp_ack_destination = ack_dest_ff;
   assign rsp_queue_slot      = slot_ff;
   assign rsp_queue_count     = count_ff;

   rxdf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rxdf_seq_table u_table (
      .clock      (clock),
      .reset      (reset),
      .tbl_req    (tbl_req),
      .dup_window (cfg.dup_window),
      .tbl_rsp    (tbl_rsp)
   );

endmodule

`default_nettype wire

// ===== sv/rxdf_checker.sv =====
// ----------------------------------------------------------------------------
// rxdf_checker
// port-level checks of the duplicate filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rxdf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic [rxdf_pkg::VERDICT_W-1:0] rsp_verdict,
   input logic                           rsp_ack_needed,
   input logic [rxdf_pkg::COUNT_W-1:0]   rsp_queue_count
);

   import rxdf_pkg::*;

   // an accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accepted word");

   // the end of busy carries the result
   a_fell_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // one word, one result
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   // the full check keeps one slot spare
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_queue_count < COUNT_W'(QUEUE_DEPTH)))
      else $error("queue count out of range");

   // acks only go out for packets that passed the transmit checks
   a_ack_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_ack_needed) |->
         (rsp_verdict == VERDICT_ACCEPTED) || (rsp_verdict == VERDICT_DUPLICATE) ||
         (rsp_verdict == VERDICT_Q_FULL))
      else $error("ack with wrong verdict");

endmodule

bind radio_rx_duplicate_filter_top rxdf_checker u_rxdf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_verdict     (rsp_verdict),
   .rsp_ack_needed  (rsp_ack_needed),
   .rsp_queue_count (rsp_queue_count)
);

`default_nettype wire
